@@ rtl/point_cloud_top_view_projector_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the top-view projector
// Immediate-consequence and next-cycle property forms, clocked on i_clk.
// ----------------------------------------------------------------------------
`ifndef POINT_CLOUD_TOP_VIEW_PROJECTOR_TOP_ASSERT_SVH
`define POINT_CLOUD_TOP_VIEW_PROJECTOR_TOP_ASSERT_SVH

// same-cycle implication
`define PCTV_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PCTV_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/pctv_pkg.sv @@
// ----------------------------------------------------------------------------
// pctv_pkg
// Image geometry, register codes, reset values and pipeline types.
// ----------------------------------------------------------------------------
package pctv_pkg;

    localparam int ImgWidth  = 640;
    localparam int ImgHeight = 480;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 16;

    localparam logic [CfgIdxW-1:0] CfgTiltCos    = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgTiltSin    = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgAreaWidth  = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgAreaDepth  = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgHeightLo   = 3'd4;
    localparam logic [CfgIdxW-1:0] CfgHeightHi   = 3'd5;
    localparam logic [CfgIdxW-1:0] CfgFullHeight = 3'd6;
    localparam logic [CfgIdxW-1:0] CfgColourMode = 3'd7;

    localparam logic signed [15:0] RstTiltCos   = 16'sd16384;
    localparam logic signed [15:0] RstTiltSin   = 16'sd0;
    localparam logic [15:0]        RstAreaWidth = 16'd4000;
    localparam logic [14:0]        RstAreaDepth = 15'd4000;
    localparam logic signed [15:0] RstHeightLo  = 16'sd0;
    localparam logic signed [15:0] RstHeightHi  = 16'sd0;

    localparam logic [7:0] MonoLevel = 8'd255;

    // restoring division, one quotient bit per stage
    localparam int QcW      = $clog2(ImgWidth);
    localparam int QrW      = $clog2(ImgHeight + 1);
    localparam int DivSteps = (QcW > QrW) ? QcW : QrW;
    localparam int ColMulW  = $clog2(ImgWidth + 1);
    localparam int ColNumW  = 17 + ColMulW;
    localparam int ColCmpW  = ColNumW + DivSteps;
    localparam int RowMulW  = $clog2(ImgHeight + 2);
    localparam int RowNumW  = 15 + RowMulW;
    localparam int RowCmpW  = RowNumW + DivSteps;

    // multiply, round, test, division steps
    localparam int NumStg = 3 + DivSteps;

    localparam int DstColW = 10;
    localparam int DstRowW = 9;

    typedef struct packed {
        logic              hit;
        logic              near;
        logic signed [15:0] rx;
        logic signed [15:0] ry;
        logic signed [15:0] rz;
        logic [7:0]        b;
        logic [7:0]        g;
        logic [7:0]        r;
        logic [9:0]        scol;
        logic [8:0]        srow;
    } t_item;

    typedef struct packed {
        logic              hit;
        logic [DstColW-1:0] dst_col;
        logic [DstRowW-1:0] dst_row;
        logic [7:0]        b;
        logic [7:0]        g;
        logic [7:0]        r;
        logic signed [15:0] rx;
        logic signed [15:0] ry;
        logic signed [15:0] rz;
        logic [9:0]        from_col;
        logic [8:0]        from_row;
    } t_res;

endpackage

@@ rtl/point_cloud_top_view_projector_top.sv @@
// ----------------------------------------------------------------------------
// point_cloud_top_view_projector_top: tilt, crop and top-view pixel mapping
// Pipeline: multiply, round and test stages, the division steps, then an output register with skid.
// Throughput: one point per cycle while o_stall is low; depth set by one division bit per stage.
// Reset: clears valid bits, skid stage and reloads register defaults.
// ----------------------------------------------------------------------------
`include "point_cloud_top_view_projector_top_assert.svh"

module point_cloud_top_view_projector_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_cfg_we,
    input  logic [pctv_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [pctv_pkg::CfgDataW-1:0] i_cfg_data,

    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [15:0]            i_px_mm,
    input  logic signed [15:0]            i_py_mm,
    input  logic signed [15:0]            i_pz_mm,
    input  logic                          i_depth_ok,
    input  logic [7:0]                    i_in_blue,
    input  logic [7:0]                    i_in_green,
    input  logic [7:0]                    i_in_red,
    input  logic [9:0]                    i_src_col,
    input  logic [8:0]                    i_src_row,

    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_hit,
    output logic [9:0]                    o_dst_col,
    output logic [8:0]                    o_dst_row,
    output logic [7:0]                    o_out_blue,
    output logic [7:0]                    o_out_green,
    output logic [7:0]                    o_out_red,
    output logic signed [15:0]            o_rot_x_mm,
    output logic signed [15:0]            o_rot_y_mm,
    output logic signed [15:0]            o_rot_z_mm,
    output logic [9:0]                    o_from_col,
    output logic [8:0]                    o_from_row
);

    localparam int NStg = pctv_pkg::NumStg;
    localparam int NDiv = pctv_pkg::DivSteps;

    logic signed [15:0] r_cos;
    logic signed [15:0] r_sin;
    logic [15:0]        r_area_w;
    logic [14:0]        r_area_d;
    logic signed [15:0] r_floor;
    logic signed [15:0] r_ceil;
    logic               r_full_height;
    logic               r_colour_mode;

    logic [NStg-1:0]    r_v;
    logic [NStg-1:0]    n_v;
    pctv_pkg::t_item    r_it [NStg];
    pctv_pkg::t_item    n_it [NStg];
    logic signed [31:0] r_m [4];
    logic signed [31:0] n_m [4];

    logic [pctv_pkg::ColNumW-1:0] r_crem [NDiv+1];
    logic [pctv_pkg::ColNumW-1:0] n_crem [NDiv+1];
    logic [pctv_pkg::RowNumW-1:0] r_rrem [NDiv+1];
    logic [pctv_pkg::RowNumW-1:0] n_rrem [NDiv+1];
    logic [NDiv-1:0]              r_cq [NDiv+1];
    logic [NDiv-1:0]              n_cq [NDiv+1];
    logic [NDiv-1:0]              r_rq [NDiv+1];
    logic [NDiv-1:0]              n_rq [NDiv+1];

    logic               en;
    pctv_pkg::t_res     p_res;
    pctv_pkg::t_res     r_out;
    pctv_pkg::t_res     r_skd;
    logic               r_out_v;
    logic               r_skd_v;
    logic               out_fire;

    function automatic logic signed [15:0] f_round_sat(input logic signed [33:0] acc);
        logic signed [33:0] t;
        logic signed [19:0] q;
        begin
            t = acc + 34'sd8192;
            q = t[33:14];
            if (q > 20'sd32767) begin
                f_round_sat = 16'sh7FFF;
            end else if (q < -20'sd32768) begin
                f_round_sat = 16'sh8000;
            end else begin
                f_round_sat = q[15:0];
            end
        end
    endfunction

    assign en       = !r_skd_v;
    assign o_stall  = r_skd_v;
    assign out_fire = r_out_v && !i_stall;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos         <= pctv_pkg::RstTiltCos;
            r_sin         <= pctv_pkg::RstTiltSin;
            r_area_w      <= pctv_pkg::RstAreaWidth;
            r_area_d      <= pctv_pkg::RstAreaDepth;
            r_floor       <= pctv_pkg::RstHeightLo;
            r_ceil        <= pctv_pkg::RstHeightHi;
            r_full_height <= 1'b1;
            r_colour_mode <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pctv_pkg::CfgTiltCos:    r_cos         <= $signed(i_cfg_data);
                pctv_pkg::CfgTiltSin:    r_sin         <= $signed(i_cfg_data);
                pctv_pkg::CfgAreaWidth:  r_area_w      <= i_cfg_data;
                pctv_pkg::CfgAreaDepth:  r_area_d      <= i_cfg_data[14:0];
                pctv_pkg::CfgHeightLo:   r_floor       <= $signed(i_cfg_data);
                pctv_pkg::CfgHeightHi:   r_ceil        <= $signed(i_cfg_data);
                pctv_pkg::CfgFullHeight: r_full_height <= i_cfg_data[0];
                pctv_pkg::CfgColourMode: r_colour_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // multiply, round, test
    always_comb begin
        logic signed [16:0] rx17;
        logic [16:0]        arx;
        logic               in_depth;
        logic               in_width;
        logic               in_height;
        pctv_pkg::t_item    it;

        n_m[0] = i_py_mm * r_cos;
        n_m[1] = i_pz_mm * r_sin;
        n_m[2] = i_py_mm * r_sin;
        n_m[3] = i_pz_mm * r_cos;

        it.hit  = i_depth_ok;
        it.near = 1'b0;
        it.rx   = i_px_mm;
        it.ry   = '0;
        it.rz   = '0;
        it.b    = i_in_blue;
        it.g    = i_in_green;
        it.r    = i_in_red;
        it.scol = i_src_col;
        it.srow = i_src_row;
        n_it[0] = it;

        it    = r_it[0];
        it.ry = f_round_sat(34'(r_m[0]) - 34'(r_m[1]));
        it.rz = f_round_sat(34'(r_m[2]) + 34'(r_m[3]));
        n_it[1] = it;

        it        = r_it[1];
        rx17      = 17'(it.rx);
        arx       = rx17[16] ? 17'(-rx17) : 17'(rx17);
        in_depth  = it.rz[15] || (it.rz[14:0] < r_area_d);
        in_width  = {arx, 1'b0} < {2'b00, r_area_w};
        in_height = r_full_height || ((it.ry > r_floor) && (it.ry < r_ceil));
        it.hit    = it.hit && in_depth && in_width && in_height;
        it.near   = it.rz[15] || (it.rz == 16'sd0);
        n_it[2]   = it;

        for (int s = 3; s < NStg; s++) begin
            n_it[s] = r_it[s-1];
        end
        n_v = {r_v[NStg-2:0], i_valid};
    end

    // division steps, most significant quotient bit first
    always_comb begin
        logic signed [17:0]           s18;
        logic [pctv_pkg::ColCmpW-1:0] cd;
        logic [pctv_pkg::ColCmpW-1:0] ce;
        logic [pctv_pkg::RowCmpW-1:0] rd;
        logic [pctv_pkg::RowCmpW-1:0] re;

        s18 = $signed({r_it[1].rx[15], r_it[1].rx, 1'b0}) + $signed({2'b00, r_area_w});
        n_crem[0] = pctv_pkg::ColNumW'(s18[16:0])
                  * pctv_pkg::ColNumW'(pctv_pkg::ImgWidth);
        n_rrem[0] = pctv_pkg::RowNumW'(r_it[1].rz[14:0])
                  * pctv_pkg::RowNumW'(pctv_pkg::ImgHeight)
                  + pctv_pkg::RowNumW'(r_area_d) - pctv_pkg::RowNumW'(1);
        n_cq[0] = '0;
        n_rq[0] = '0;

        for (int k = 0; k < NDiv; k++) begin
            cd = pctv_pkg::ColCmpW'({r_area_w, 1'b0}) << (NDiv - 1 - k);
            ce = pctv_pkg::ColCmpW'(r_crem[k]);
            rd = pctv_pkg::RowCmpW'(r_area_d) << (NDiv - 1 - k);
            re = pctv_pkg::RowCmpW'(r_rrem[k]);
            if (ce >= cd) begin
                n_crem[k+1] = pctv_pkg::ColNumW'(ce - cd);
                n_cq[k+1]   = {r_cq[k][NDiv-2:0], 1'b1};
            end else begin
                n_crem[k+1] = r_crem[k];
                n_cq[k+1]   = {r_cq[k][NDiv-2:0], 1'b0};
            end
            if (re >= rd) begin
                n_rrem[k+1] = pctv_pkg::RowNumW'(re - rd);
                n_rq[k+1]   = {r_rq[k][NDiv-2:0], 1'b1};
            end else begin
                n_rrem[k+1] = r_rrem[k];
                n_rq[k+1]   = {r_rq[k][NDiv-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int s = 0; s < NStg; s++) begin
                r_it[s] <= n_it[s];
            end
            for (int j = 0; j < 4; j++) begin
                r_m[j] <= n_m[j];
            end
            for (int k = 0; k <= NDiv; k++) begin
                r_crem[k] <= n_crem[k];
                r_rrem[k] <= n_rrem[k];
                r_cq[k]   <= n_cq[k];
                r_rq[k]   <= n_rq[k];
            end
        end
    end

    // clamp, gate and form the result
    always_comb begin
        logic [NDiv-1:0] cq;
        logic [NDiv-1:0] rq;
        logic [NDiv-1:0] colv;
        logic [NDiv-1:0] rowv;
        pctv_pkg::t_item it;
        it = r_it[NStg-1];
        cq = r_cq[NDiv];
        rq = r_rq[NDiv];
        colv = (cq > NDiv'(pctv_pkg::ImgWidth - 1)) ? NDiv'(pctv_pkg::ImgWidth - 1) : cq;
        if (it.near || (rq == '0)) begin
            rowv = NDiv'(pctv_pkg::ImgHeight - 1);
        end else if (rq >= NDiv'(pctv_pkg::ImgHeight)) begin
            rowv = '0;
        end else begin
            rowv = NDiv'(pctv_pkg::ImgHeight) - rq;
        end
        p_res.hit      = it.hit;
        p_res.dst_col  = it.hit ? pctv_pkg::DstColW'(colv) : '0;
        p_res.dst_row  = it.hit ? pctv_pkg::DstRowW'(rowv) : '0;
        p_res.b        = !it.hit ? 8'd0 : (r_colour_mode ? it.b : pctv_pkg::MonoLevel);
        p_res.g        = !it.hit ? 8'd0 : (r_colour_mode ? it.g : pctv_pkg::MonoLevel);
        p_res.r        = !it.hit ? 8'd0 : (r_colour_mode ? it.r : pctv_pkg::MonoLevel);
        p_res.rx       = it.rx;
        p_res.ry       = it.ry;
        p_res.rz       = it.rz;
        p_res.from_col = it.scol;
        p_res.from_row = it.srow;
    end

    // output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_skd_v <= 1'b0;
        end else if (!r_out_v || out_fire) begin
            if (r_skd_v) begin
                r_out_v <= 1'b1;
                r_skd_v <= 1'b0;
            end else begin
                r_out_v <= r_v[NStg-1];
            end
        end else if (r_v[NStg-1] && en) begin
            r_skd_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || out_fire) begin
            r_out <= r_skd_v ? r_skd : p_res;
        end else if (en) begin
            r_skd <= p_res;
        end
    end

    assign o_valid     = r_out_v;
    assign o_hit       = r_out.hit;
    assign o_dst_col   = r_out.dst_col;
    assign o_dst_row   = r_out.dst_row;
    assign o_out_blue  = r_out.b;
    assign o_out_green = r_out.g;
    assign o_out_red   = r_out.r;
    assign o_rot_x_mm  = r_out.rx;
    assign o_rot_y_mm  = r_out.ry;
    assign o_rot_z_mm  = r_out.rz;
    assign o_from_col  = r_out.from_col;
    assign o_from_row  = r_out.from_row;

    `PCTV_ASSERT_IMP(a_skid_needs_out, r_skd_v, r_out_v, "skid full with output empty")
    `PCTV_ASSERT_IMP(a_skid_fill_cause, $rose(r_skd_v), $past(r_out_v && i_stall),
                     "skid filled without a stalled output")
    `PCTV_ASSERT_NXT(a_skid_catch, r_out_v && i_stall && r_v[NStg-1] && !r_skd_v, r_skd_v,
                     "result lost behind a stalled output")
    `PCTV_ASSERT_IMP(a_miss_zero, r_out_v && !r_out.hit,
                     (r_out.dst_col == '0) && (r_out.dst_row == '0) && (r_out.b == 8'd0)
                     && (r_out.g == 8'd0) && (r_out.r == 8'd0),
                     "missed point carries pixel data")

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Top-view projector testbench
// Drives a table of directed points and then phases of random points, each
// phase under its own register setting. Every result transfer is checked
// field by field against its expected pixel, from the table or from a local
// projection of the point. Sender and receiver idle at random, and the
// receiver holds off once long enough to back the pipeline up into the input.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CycleLimit = 300000;
    localparam int TailCycles = 4 + pctv_pkg::DivSteps + 6;

    typedef struct packed {
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] pz;
        logic               depth_ok;
        logic [7:0]         b;
        logic [7:0]         g;
        logic [7:0]         r;
        logic [9:0]         src_col;
        logic [8:0]         src_row;
    } t_point;

    typedef struct {
        logic           is_cfg;
        logic [2:0]     idx;
        logic [15:0]    value;
        logic           typed;
        t_point         p;
        pctv_pkg::t_res want;
    } t_plan_row;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [pctv_pkg::CfgIdxW-1:0] cfg_idx = '0;
    logic [pctv_pkg::CfgDataW-1:0] cfg_data = '0;
    logic pt_valid = 1'b0;
    logic pt_stall;
    logic signed [15:0] pt_px = '0;
    logic signed [15:0] pt_py = '0;
    logic signed [15:0] pt_pz = '0;
    logic pt_depth_ok = 1'b0;
    logic [7:0] pt_blue = '0;
    logic [7:0] pt_green = '0;
    logic [7:0] pt_red = '0;
    logic [9:0] pt_src_col = '0;
    logic [8:0] pt_src_row = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    logic res_hit;
    logic [9:0] res_dst_col;
    logic [8:0] res_dst_row;
    logic [7:0] res_blue;
    logic [7:0] res_green;
    logic [7:0] res_red;
    logic signed [15:0] res_rot_x;
    logic signed [15:0] res_rot_y;
    logic signed [15:0] res_rot_z;
    logic [9:0] res_from_col;
    logic [8:0] res_from_row;

    logic signed [15:0] tilt_cos = pctv_pkg::RstTiltCos;
    logic signed [15:0] tilt_sin = pctv_pkg::RstTiltSin;
    logic [15:0] area_w = pctv_pkg::RstAreaWidth;
    logic [14:0] area_d = pctv_pkg::RstAreaDepth;
    logic signed [15:0] floor_mm = pctv_pkg::RstHeightLo;
    logic signed [15:0] ceil_mm = pctv_pkg::RstHeightHi;
    logic full_height = 1'b1;
    logic colour_mode = 1'b1;

    pctv_pkg::t_res awaited_pixels[$];
    t_plan_row plan[$];
    int mismatches = 0;
    int results_seen = 0;
    int tx_idle_pct = 20;
    int rx_idle_pct = 58;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int unsigned cycle_count = 0;

    point_cloud_top_view_projector_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_valid     (pt_valid),
        .o_stall     (pt_stall),
        .i_px_mm     (pt_px),
        .i_py_mm     (pt_py),
        .i_pz_mm     (pt_pz),
        .i_depth_ok  (pt_depth_ok),
        .i_in_blue   (pt_blue),
        .i_in_green  (pt_green),
        .i_in_red    (pt_red),
        .i_src_col   (pt_src_col),
        .i_src_row   (pt_src_row),
        .o_valid     (res_valid),
        .i_stall     (res_stall),
        .o_hit       (res_hit),
        .o_dst_col   (res_dst_col),
        .o_dst_row   (res_dst_row),
        .o_out_blue  (res_blue),
        .o_out_green (res_green),
        .o_out_red   (res_red),
        .o_rot_x_mm  (res_rot_x),
        .o_rot_y_mm  (res_rot_y),
        .o_rot_z_mm  (res_rot_z),
        .o_from_col  (res_from_col),
        .o_from_row  (res_from_row)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic longint round_sat_q14(input longint acc);
        longint r;
        r = (acc + 8192) >>> 14;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r;
    endfunction

    function automatic pctv_pkg::t_res project_point(input t_point p);
        pctv_pkg::t_res e;
        longint rx, ry, rz, arx, w_mm, d_mm, col, row;
        logic keep;
        w_mm = longint'(area_w);
        d_mm = longint'(area_d);
        rx = longint'(p.px);
        ry = round_sat_q14(longint'(p.py) * tilt_cos - longint'(p.pz) * tilt_sin);
        rz = round_sat_q14(longint'(p.py) * tilt_sin + longint'(p.pz) * tilt_cos);
        arx = (rx < 0) ? -rx : rx;
        keep = p.depth_ok && (rz < d_mm) && (2 * arx < w_mm);
        if (!full_height)
            keep = keep && (ry > longint'(floor_mm)) && (ry < longint'(ceil_mm));
        e = '0;
        e.hit = keep;
        e.rx = 16'(rx);
        e.ry = 16'(ry);
        e.rz = 16'(rz);
        e.from_col = p.src_col;
        e.from_row = p.src_row;
        if (keep) begin
            col = 0;
            if (w_mm > 0) col = ((2 * rx + w_mm) * pctv_pkg::ImgWidth) / (2 * w_mm);
            if (col < 0) col = 0;
            if (col > pctv_pkg::ImgWidth - 1) col = pctv_pkg::ImgWidth - 1;
            if (rz <= 0 || d_mm <= 0) begin
                row = pctv_pkg::ImgHeight - 1;
            end else begin
                row = pctv_pkg::ImgHeight - (rz * pctv_pkg::ImgHeight + d_mm - 1) / d_mm;
            end
            if (row < 0) row = 0;
            if (row > pctv_pkg::ImgHeight - 1) row = pctv_pkg::ImgHeight - 1;
            e.dst_col = 10'(col);
            e.dst_row = 9'(row);
            e.b = colour_mode ? p.b : pctv_pkg::MonoLevel;
            e.g = colour_mode ? p.g : pctv_pkg::MonoLevel;
            e.r = colour_mode ? p.r : pctv_pkg::MonoLevel;
        end
        return e;
    endfunction

    function automatic t_point mk_point(input int px, py, pz, input bit ok,
                                        input int b, g, r, c, rw);
        t_point p;
        p.px = 16'(px);
        p.py = 16'(py);
        p.pz = 16'(pz);
        p.depth_ok = ok;
        p.b = 8'(b);
        p.g = 8'(g);
        p.r = 8'(r);
        p.src_col = 10'(c);
        p.src_row = 9'(rw);
        return p;
    endfunction

    function automatic pctv_pkg::t_res mk_pixel(input bit hit, input int col, row, b, g, r,
                                                input int rx, ry, rz, fc, fr);
        pctv_pkg::t_res e;
        e.hit = hit;
        e.dst_col = 10'(col);
        e.dst_row = 9'(row);
        e.b = 8'(b);
        e.g = 8'(g);
        e.r = 8'(r);
        e.rx = 16'(rx);
        e.ry = 16'(ry);
        e.rz = 16'(rz);
        e.from_col = 10'(fc);
        e.from_row = 9'(fr);
        return e;
    endfunction

    function automatic t_plan_row cfg_row(input logic [2:0] idx, input int value);
        t_plan_row row;
        row.is_cfg = 1'b1;
        row.idx = idx;
        row.value = 16'(value);
        row.typed = 1'b0;
        row.p = '0;
        row.want = '0;
        return row;
    endfunction

    function automatic t_plan_row point_row(input t_point p, input bit typed,
                                            input pctv_pkg::t_res want);
        t_plan_row row;
        row.is_cfg = 1'b0;
        row.idx = '0;
        row.value = '0;
        row.typed = typed;
        row.p = p;
        row.want = want;
        return row;
    endfunction

    function automatic void add_row(input t_plan_row row);
        plan = {plan, row};
    endfunction

    function automatic t_point random_point();
        t_point p;
        int half;
        half = int'(area_w) / 2;
        if ($urandom_range(9) < 7) begin
            p.px = 16'(int'($urandom_range(2 * half)) - half);
            p.py = 16'(int'($urandom_range(4000)) - 2000);
            p.pz = 16'($urandom_range(int'(area_d) + 200));
            p.depth_ok = ($urandom_range(15) != 0);
        end else begin
            p.px = 16'($urandom);
            p.py = 16'($urandom);
            p.pz = 16'($urandom);
            p.depth_ok = 1'($urandom);
        end
        p.b = 8'($urandom);
        p.g = 8'($urandom);
        p.r = 8'($urandom);
        p.src_col = 10'($urandom);
        p.src_row = 9'($urandom);
        return p;
    endfunction

    function automatic void check_field(input string name,
                                        input logic signed [31:0] want, got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic write_reg(input logic [2:0] idx, input int value);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= 16'(value);
        case (idx)
            pctv_pkg::CfgTiltCos:    tilt_cos = 16'(value);
            pctv_pkg::CfgTiltSin:    tilt_sin = 16'(value);
            pctv_pkg::CfgAreaWidth:  area_w = 16'(value);
            pctv_pkg::CfgAreaDepth:  area_d = 15'(value);
            pctv_pkg::CfgHeightLo:   floor_mm = 16'(value);
            pctv_pkg::CfgHeightHi:   ceil_mm = 16'(value);
            pctv_pkg::CfgFullHeight: full_height = 1'(value);
            pctv_pkg::CfgColourMode: colour_mode = 1'(value);
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_point(input t_point p, input bit typed, input pctv_pkg::t_res want);
        if ($urandom_range(99) < tx_idle_pct) begin
            pt_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
        end
        pt_valid <= 1'b1;
        pt_px <= p.px;
        pt_py <= p.py;
        pt_pz <= p.pz;
        pt_depth_ok <= p.depth_ok;
        pt_blue <= p.b;
        pt_green <= p.g;
        pt_red <= p.r;
        pt_src_col <= p.src_col;
        pt_src_row <= p.src_row;
        do @(posedge clk); while (pt_stall);
        awaited_pixels = {awaited_pixels, (typed ? want : project_point(p))};
    endtask

    task automatic flush_pipeline();
        pt_valid <= 1'b0;
        while (awaited_pixels.size() != 0) @(posedge clk);
        repeat (TailCycles) @(posedge clk);
    endtask

    always @(posedge clk) begin
        pctv_pkg::t_res want;
        if (rst_n && res_valid && !res_stall) begin
            if (awaited_pixels.size() == 0) begin
                $error("result transfer with no point pending");
                mismatches++;
            end else begin
                want = awaited_pixels.pop_front();
                check_field("hit", want.hit, res_hit);
                check_field("dst_col", want.dst_col, res_dst_col);
                check_field("dst_row", want.dst_row, res_dst_row);
                check_field("out_blue", want.b, res_blue);
                check_field("out_green", want.g, res_green);
                check_field("out_red", want.r, res_red);
                check_field("rot_x_mm", want.rx, res_rot_x);
                check_field("rot_y_mm", want.ry, res_rot_y);
                check_field("rot_z_mm", want.rz, res_rot_z);
                check_field("from_col", want.from_col, res_from_col);
                check_field("from_row", want.from_row, res_from_row);
            end
            results_seen++;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_stall <= 1'b1;
        end else if (!hold_done && results_seen == 150) begin
            hold_done = 1'b1;
            hold_left = 400;
            res_stall <= 1'b1;
        end else begin
            res_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    initial begin
        while (cycle_count < CycleLimit) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin
        add_row(point_row(mk_point(0, 0, 0, 1, 0, 0, 0, 0, 0), 1,
                          mk_pixel(1, 320, 479, 0, 0, 0, 0, 0, 0, 0, 0)));
        add_row(point_row(mk_point(32767, -32768, 32767, 0, 255, 255, 255, 1023, 511), 1,
                          mk_pixel(0, 0, 0, 0, 0, 0, 32767, -32768, 32767, 1023, 511)));
        add_row(point_row(mk_point(-32768, 32767, -32768, 1, 170, 85, 60, 639, 479), 1,
                          mk_pixel(0, 0, 0, 0, 0, 0, -32768, 32767, -32768, 639, 479)));
        add_row(point_row(mk_point(1999, 5, 3999, 1, 1, 2, 3, 100, 200), 1,
                          mk_pixel(1, 639, 0, 1, 2, 3, 1999, 5, 3999, 100, 200)));
        add_row(point_row(mk_point(2000, 0, 100, 1, 4, 5, 6, 1, 2), 1,
                          mk_pixel(0, 0, 0, 0, 0, 0, 2000, 0, 100, 1, 2)));
        add_row(point_row(mk_point(0, 0, 4000, 1, 4, 5, 6, 3, 4), 1,
                          mk_pixel(0, 0, 0, 0, 0, 0, 0, 0, 4000, 3, 4)));
        add_row(point_row(mk_point(-1999, -7, 1, 1, 9, 8, 7, 5, 6), 1,
                          mk_pixel(1, 0, 479, 9, 8, 7, -1999, -7, 1, 5, 6)));
        add_row(point_row(mk_point(0, 0, -500, 1, 20, 30, 40, 11, 12), 1,
                          mk_pixel(1, 320, 479, 20, 30, 40, 0, 0, -500, 11, 12)));
        add_row(cfg_row(pctv_pkg::CfgColourMode, 0));
        add_row(point_row(mk_point(100, 0, 2000, 1, 12, 34, 56, 7, 8), 1,
                          mk_pixel(1, 336, 240, 255, 255, 255, 100, 0, 2000, 7, 8)));
        add_row(cfg_row(pctv_pkg::CfgFullHeight, 0));
        add_row(cfg_row(pctv_pkg::CfgHeightLo, -100));
        add_row(cfg_row(pctv_pkg::CfgHeightHi, 100));
        add_row(point_row(mk_point(0, -100, 1000, 1, 1, 1, 1, 0, 0), 1,
                          mk_pixel(0, 0, 0, 0, 0, 0, 0, -100, 1000, 0, 0)));
        add_row(point_row(mk_point(0, 99, 1000, 1, 2, 2, 2, 1, 1), 0, '0));
        add_row(point_row(mk_point(0, 100, 1000, 1, 3, 3, 3, 2, 2), 1,
                          mk_pixel(0, 0, 0, 0, 0, 0, 0, 100, 1000, 2, 2)));
        add_row(cfg_row(pctv_pkg::CfgTiltCos, -16384));
        add_row(cfg_row(pctv_pkg::CfgTiltSin, 16384));
        add_row(point_row(mk_point(-32768, -32768, 32767, 1, 90, 91, 92, 3, 3), 0, '0));
        add_row(point_row(mk_point(5, 32767, -32768, 1, 93, 94, 95, 4, 4), 0, '0));
        add_row(cfg_row(pctv_pkg::CfgTiltCos, 8192));
        add_row(cfg_row(pctv_pkg::CfgTiltSin, 0));
        add_row(point_row(mk_point(0, 1, -1, 1, 10, 11, 12, 5, 5), 0, '0));
        add_row(point_row(mk_point(0, -1, 3, 1, 13, 14, 15, 6, 6), 0, '0));
        add_row(cfg_row(pctv_pkg::CfgFullHeight, 1));
        add_row(cfg_row(pctv_pkg::CfgColourMode, 1));
        add_row(cfg_row(pctv_pkg::CfgAreaWidth, 0));
        add_row(cfg_row(pctv_pkg::CfgAreaDepth, 0));
        add_row(point_row(mk_point(0, 0, -10, 1, 16, 17, 18, 7, 7), 0, '0));
        add_row(cfg_row(pctv_pkg::CfgAreaWidth, 4000));
        add_row(point_row(mk_point(0, 0, -10, 1, 19, 20, 21, 8, 8), 0, '0));
        add_row(cfg_row(pctv_pkg::CfgTiltCos, 16384));
        add_row(cfg_row(pctv_pkg::CfgAreaWidth, 65535));
        add_row(cfg_row(pctv_pkg::CfgAreaDepth, 32767));
        add_row(point_row(mk_point(32767, -3, 32766, 1, 22, 23, 24, 9, 9), 0, '0));
        add_row(point_row(mk_point(-32768, 0, -32768, 1, 25, 26, 27, 10, 10), 0, '0));
        add_row(cfg_row(pctv_pkg::CfgAreaWidth, 1));
        add_row(cfg_row(pctv_pkg::CfgAreaDepth, 1));
        add_row(point_row(mk_point(0, 0, 0, 1, 77, 88, 99, 600, 400), 1,
                          mk_pixel(1, 320, 479, 77, 88, 99, 0, 0, 0, 600, 400)));
        add_row(point_row(mk_point(0, 0, 1, 1, 28, 29, 30, 11, 11), 0, '0));
        add_row(cfg_row(pctv_pkg::CfgAreaWidth, 4000));
        add_row(cfg_row(pctv_pkg::CfgAreaDepth, 4000));
        add_row(cfg_row(pctv_pkg::CfgHeightLo, -32768));
        add_row(cfg_row(pctv_pkg::CfgHeightHi, 32767));
        add_row(cfg_row(pctv_pkg::CfgFullHeight, 0));
        add_row(point_row(mk_point(0, -32768, 100, 1, 31, 32, 33, 12, 12), 0, '0));
        add_row(point_row(mk_point(0, 32767, 100, 1, 34, 35, 36, 13, 13), 0, '0));
        add_row(point_row(mk_point(0, -32767, 100, 1, 37, 38, 39, 14, 14), 0, '0));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                flush_pipeline();
                write_reg(plan[i].idx, plan[i].value);
            end else begin
                send_point(plan[i].p, plan[i].typed, plan[i].want);
            end
        end

        for (int phase = 0; phase < 8; phase++) begin
            flush_pipeline();
            if (phase < 3) begin
                tx_idle_pct = 20;
                rx_idle_pct = 58;
            end else if (phase < 6) begin
                tx_idle_pct = 58;
                rx_idle_pct = 20;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            write_reg(pctv_pkg::CfgTiltCos,
                      (phase == 4) ? -int'($urandom_range(16384, 11000))
                                   : int'($urandom_range(16384, 11000)));
            write_reg(pctv_pkg::CfgTiltSin, int'($urandom_range(12000)) - 6000);
            write_reg(pctv_pkg::CfgAreaWidth, $urandom_range(8000, 500));
            write_reg(pctv_pkg::CfgAreaDepth, $urandom_range(8000, 500));
            write_reg(pctv_pkg::CfgHeightLo, -int'($urandom_range(2000)));
            write_reg(pctv_pkg::CfgHeightHi, $urandom_range(2000));
            write_reg(pctv_pkg::CfgFullHeight, $urandom_range(1));
            write_reg(pctv_pkg::CfgColourMode, $urandom_range(1));
            repeat (100) send_point(random_point(), 1'b0, '0);
        end

        flush_pipeline();
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
